// ===== sv/integer_to_ascii_formatter_macros.svh =====
// Assertion helpers for the formatter RTL.
`ifndef INTEGER_TO_ASCII_FORMATTER_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ITOA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define ITOA_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/itoa_pkg.sv =====
`timescale 1ns / 1ps

package itoa_pkg;

   // Operand port width and default significant bits
   localparam int VAL_W      = 32;
   localparam int VAL_BITS   = 32;
   // Digit positions scanned on output (decimal digits of a 32-bit value)
   localparam int DIGITS     = 10;
   localparam int WIDTH_W    = 4;
   localparam int CHAR_W     = 7;

   localparam logic [WIDTH_W-1:0] MAX_MIN_WIDTH = 4'd9;
   localparam logic [WIDTH_W-1:0] PTR_DIGITS    = 4'd8;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
   localparam logic [CHAR_W-1:0] CHAR_A     = 7'h61;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
   localparam logic [CHAR_W-1:0] CHAR_X     = 7'h78;

   typedef enum logic [1:0] {
      OP_SDEC = 2'd0,
      OP_UDEC = 2'd1,
      OP_HEX  = 2'd2,
      OP_PTR  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_SIGN,
      ST_PFX0,
      ST_PFXX,
      ST_DIGITS
   } state_type;

   // Control from the sequencer to the radix converter
   typedef struct packed {
      logic start;
      logic dec;
      logic pop;
   } conv_ctl_type;

   // Status from the radix converter
   typedef struct packed {
      logic       busy;
      logic [3:0] digit;
   } conv_sts_type;

   // Map a digit value to its lowercase ASCII character
   function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
      logic [CHAR_W-1:0] c;
      if (d < 4'd10) begin
         c = CHAR_ZERO + {3'd0, d};
      end else begin
         c = CHAR_A + {3'd0, d} - 7'd10;
      end
      return c;
   endfunction

endpackage

// ===== sv/itoa_radix_conv.sv =====
`timescale 1ns / 1ps

module itoa_radix_conv #(
   parameter int OP_BITS = itoa_pkg::VAL_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  itoa_pkg::conv_ctl_type ctl,
   input  logic [OP_BITS-1:0]     mag,
   output itoa_pkg::conv_sts_type sts
);

   localparam int CNT_W = $clog2(OP_BITS + 1);
   localparam int DIG_W = itoa_pkg::DIGITS * 4;

   logic [OP_BITS-1:0] bin_ff, bin_in;
   logic [DIG_W-1:0]   dig_ff, dig_in;
   logic [DIG_W-1:0]   adj;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               run_ff, run_in;
   logic               dec_ff, dec_in;

   // In decimal mode, add three to every digit of five or more before the shift
   always_comb begin
      for (int i = 0; i < itoa_pkg::DIGITS; i++) begin
         if (dec_ff && (dig_ff[i*4 +: 4] >= 4'd5)) begin
            adj[i*4 +: 4] = dig_ff[i*4 +: 4] + 4'd3;
         end else begin
            adj[i*4 +: 4] = dig_ff[i*4 +: 4];
         end
      end
   end

   // Load, shift one operand bit in per cycle, or pop the top digit
   always_comb begin
      bin_in = bin_ff;
      dig_in = dig_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      dec_in = dec_ff;
      priority if (ctl.start) begin
         bin_in = mag;
         dig_in = '0;
         cnt_in = CNT_W'(OP_BITS);
         run_in = 1'b1;
         dec_in = ctl.dec;
      end else if (run_ff) begin
         bin_in = {bin_ff[OP_BITS-2:0], 1'b0};
         dig_in = {adj[DIG_W-2:0], bin_ff[OP_BITS-1]};
         cnt_in = cnt_ff - CNT_W'(1);
         run_in = (cnt_ff != CNT_W'(1));
      end else if (ctl.pop) begin
         dig_in = {dig_ff[DIG_W-5:0], 4'd0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
      bin_ff <= bin_in;
      dig_ff <= dig_in;
      dec_ff <= dec_in;
   end

   assign sts.busy  = run_ff;
   assign sts.digit = dig_ff[DIG_W-1 -: 4];

endmodule

// ===== sv/integer_to_ascii_formatter.sv =====
`timescale 1ns / 1ps
// Integer-to-ASCII formatter: each request carries a 32-bit value, a conversion
// kind (signed decimal, unsigned decimal, hex with "0x", or pointer hex padded
// to 8 digits) and a minimum digit count (saturated at 9). The block returns
// the characters one per response, most significant first, with rsp_last on
// the final one; hex digits are lowercase. Only the low min(VALUE_BITS, 32)
// bits of the value are used. One request is in work at a time. From one accepted
// request to the next the block accepts, shifts one operand bit per cycle through
// the serial binary-to-digit shift register, sees the conversion finish, then
// emits each sign or prefix character and scans out each of the ten digit
// positions, leading zeros included; the response side can stall each emitted
// character.
`include "integer_to_ascii_formatter_macros.svh"

module integer_to_ascii_formatter #(
   parameter int VALUE_BITS = itoa_pkg::VAL_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_op,
   input  logic [itoa_pkg::VAL_W-1:0]          req_value,
   input  logic [itoa_pkg::WIDTH_W-1:0]        req_min_width,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [itoa_pkg::CHAR_W-1:0]         rsp_ascii_char,
   output logic                                rsp_last
);

   localparam int OP_BITS = (VALUE_BITS > itoa_pkg::VAL_W) ? itoa_pkg::VAL_W : VALUE_BITS;
   localparam bit SIGN_IN = (VALUE_BITS <= itoa_pkg::VAL_W);
   localparam int WW      = itoa_pkg::WIDTH_W;

   itoa_pkg::state_type   state_ff, state_in;
   itoa_pkg::op_type      op_ff, op_in, req_op_e;
   logic                  neg_ff, neg_in;
   logic [WW-1:0]         width_ff, width_in;
   logic [WW-1:0]         pos_ff, pos_in;
   logic                  seen_ff, seen_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [itoa_pkg::CHAR_W-1:0] rsp_char_ff, rsp_char_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  accept;
   logic                  out_free;
   logic                  req_neg;
   logic [OP_BITS-1:0]    req_bits;
   logic [OP_BITS-1:0]    req_mag;
   logic                  digit_needed;
   logic                  emit;
   logic [itoa_pkg::CHAR_W-1:0] emit_char;
   logic                  emit_last;
   logic                  step;

   itoa_pkg::conv_ctl_type conv_ctl;
   itoa_pkg::conv_sts_type conv_sts;

   assign req_ready = (state_ff == itoa_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_op_e  = itoa_pkg::op_type'(req_op);

   // Take the magnitude of a negative signed operand
   assign req_bits = req_value[OP_BITS-1:0];
   assign req_neg  = SIGN_IN && (req_op_e == itoa_pkg::OP_SDEC) && req_bits[OP_BITS-1];
   assign req_mag  = req_neg ? (~req_bits + OP_BITS'(1)) : req_bits;

   // Emit a digit once it is significant, a padding zero, or the ones digit
   assign digit_needed = seen_ff || (conv_sts.digit != 4'd0) || (pos_ff < width_ff) ||
                         (pos_ff == '0);

   itoa_radix_conv #(
      .OP_BITS (OP_BITS)
   ) u_conv (
      .clock (clock),
      .reset (reset),
      .ctl   (conv_ctl),
      .mag   (req_mag),
      .sts   (conv_sts)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         itoa_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = itoa_pkg::ST_CONV;
            end
         end
         itoa_pkg::ST_CONV: begin
            if (!conv_sts.busy) begin
               priority if (neg_ff) begin
                  state_in = itoa_pkg::ST_SIGN;
               end else if (op_ff == itoa_pkg::OP_HEX || op_ff == itoa_pkg::OP_PTR) begin
                  state_in = itoa_pkg::ST_PFX0;
               end else begin
                  state_in = itoa_pkg::ST_DIGITS;
               end
            end
         end
         itoa_pkg::ST_SIGN: begin
            if (out_free) begin
               state_in = itoa_pkg::ST_DIGITS;
            end
         end
         itoa_pkg::ST_PFX0: begin
            if (out_free) begin
               state_in = itoa_pkg::ST_PFXX;
            end
         end
         itoa_pkg::ST_PFXX: begin
            if (out_free) begin
               state_in = itoa_pkg::ST_DIGITS;
            end
         end
         itoa_pkg::ST_DIGITS: begin
            if ((pos_ff == '0) && out_free) begin
               state_in = itoa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = itoa_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs: pick the character to emit and advance the digit scan
   always_comb begin
      emit      = 1'b0;
      emit_char = itoa_pkg::CHAR_ZERO;
      emit_last = 1'b0;
      step      = 1'b0;
      unique case (state_ff)
         itoa_pkg::ST_SIGN: begin
            emit      = out_free;
            emit_char = itoa_pkg::CHAR_MINUS;
         end
         itoa_pkg::ST_PFX0: begin
            emit      = out_free;
            emit_char = itoa_pkg::CHAR_ZERO;
         end
         itoa_pkg::ST_PFXX: begin
            emit      = out_free;
            emit_char = itoa_pkg::CHAR_X;
         end
         itoa_pkg::ST_DIGITS: begin
            emit      = digit_needed && out_free;
            emit_char = itoa_pkg::digit_char(conv_sts.digit);
            emit_last = (pos_ff == '0);
            step      = !digit_needed || out_free;
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   assign conv_ctl.start = accept;
   assign conv_ctl.dec   = (req_op_e == itoa_pkg::OP_SDEC) || (req_op_e == itoa_pkg::OP_UDEC);
   assign conv_ctl.pop   = step;

   // Capture the request and track the digit position
   always_comb begin
      op_in    = op_ff;
      neg_in   = neg_ff;
      width_in = width_ff;
      pos_in   = pos_ff;
      seen_in  = seen_ff;
      if (accept) begin
         op_in  = req_op_e;
         neg_in = req_neg;
         priority if (req_op_e == itoa_pkg::OP_PTR) begin
            width_in = itoa_pkg::PTR_DIGITS;
         end else if (req_min_width > itoa_pkg::MAX_MIN_WIDTH) begin
            width_in = itoa_pkg::MAX_MIN_WIDTH;
         end else begin
            width_in = req_min_width;
         end
         pos_in  = WW'(itoa_pkg::DIGITS - 1);
         seen_in = 1'b0;
      end else if (step) begin
         pos_in  = pos_ff - WW'(1);
         seen_in = seen_ff || emit;
      end
   end

   // Hold a character until the response side takes it
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      priority if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = emit_char;
         rsp_last_in  = emit_last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= itoa_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      neg_ff      <= neg_in;
      width_ff    <= width_in;
      pos_ff      <= pos_in;
      seen_ff     <= seen_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ascii_char = rsp_char_ff;
   assign rsp_last       = rsp_last_ff;

   `ITOA_ASSERT(a_idle_conv_quiet, clock, reset, req_ready |-> !conv_sts.busy, "converter busy while idle")
   `ITOA_ASSERT(a_busy_in_conv, clock, reset, conv_sts.busy |-> (state_ff == itoa_pkg::ST_CONV), "converter busy outside conversion")
   `ITOA_ASSERT(a_last_ends_item, clock, reset, (emit && emit_last) |=> (state_ff == itoa_pkg::ST_IDLE), "last character did not end the request")

endmodule

// ===== dv/tb_integer_to_ascii_formatter.sv =====
`timescale 1ns / 1ps

module tb_integer_to_ascii_formatter;

   typedef struct packed {
      itoa_pkg::op_type op;
      logic [31:0]      value;
      logic [3:0]       min_w;
   } number_request_type;

   typedef struct {
      logic [itoa_pkg::CHAR_W-1:0] ch;
      logic                        last;
   } expected_char_type;

   localparam int NUM_DIRECTED = 20;
   localparam int NUM_RANDOM   = 350;
   localparam int DRAIN_CYCLES = 60;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_op = itoa_pkg::OP_SDEC;
   logic [itoa_pkg::VAL_W-1:0] req_value = '0;
   logic [itoa_pkg::WIDTH_W-1:0] req_min_width = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [itoa_pkg::CHAR_W-1:0] rsp_ascii_char;
   logic rsp_last;

   expected_char_type pending_chars[$];
   int mismatches = 0;
   int chars_seen = 0;
   int requests_sent = 0;
   int op_count[4] = '{0, 0, 0, 0};
   int burst_left = 0;
   int hold_asked = 0;
   int hold_served = 0;
   int hold_left = 0;
   int segment_left = 0;
   int segment_mode = 0;

   // Directed requests; a non-empty text is the exact expected output
   number_request_type directed_rows[NUM_DIRECTED] = '{
      '{itoa_pkg::OP_SDEC, 32'h0000_0000, 4'd0},
      '{itoa_pkg::OP_SDEC, 32'h0000_0000, 4'd9},
      '{itoa_pkg::OP_SDEC, 32'h8000_0000, 4'd0},
      '{itoa_pkg::OP_SDEC, 32'h8000_0000, 4'd9},
      '{itoa_pkg::OP_SDEC, 32'h7FFF_FFFF, 4'd0},
      '{itoa_pkg::OP_SDEC, 32'hFFFF_FFFF, 4'd3},
      '{itoa_pkg::OP_UDEC, 32'hFFFF_FFFF, 4'd0},
      '{itoa_pkg::OP_UDEC, 32'h0000_0000, 4'd15},
      '{itoa_pkg::OP_UDEC, 32'd12345,     4'd5},
      '{itoa_pkg::OP_UDEC, 32'd42,        4'd10},
      '{itoa_pkg::OP_HEX,  32'h0000_0000, 4'd0},
      '{itoa_pkg::OP_HEX,  32'hFFFF_FFFF, 4'd0},
      '{itoa_pkg::OP_HEX,  32'h00AB_CDEF, 4'd9},
      '{itoa_pkg::OP_HEX,  32'h0000_0001, 4'd15},
      '{itoa_pkg::OP_PTR,  32'h0000_0000, 4'd0},
      '{itoa_pkg::OP_PTR,  32'hDEAD_BEEF, 4'd9},
      '{itoa_pkg::OP_PTR,  32'h0000_1234, 4'd15},
      '{itoa_pkg::OP_SDEC, 32'hFFFF_FC18, 4'd6},
      '{itoa_pkg::OP_UDEC, 32'hA5A5_A5A5, 4'd7},
      '{itoa_pkg::OP_HEX,  32'h5A5A_5A5A, 4'd12}
   };

   string directed_text[NUM_DIRECTED] = '{
      "0",
      "000000000",
      "-2147483648",
      "-2147483648",
      "2147483647",
      "-001",
      "4294967295",
      "000000000",
      "12345",
      "000000042",
      "0x0",
      "0xffffffff",
      "0x000abcdef",
      "0x000000001",
      "0x00000000",
      "0xdeadbeef",
      "0x00001234",
      "",
      "",
      ""
   };

   integer_to_ascii_formatter u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_value      (req_value),
      .req_min_width  (req_min_width),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_ascii_char (rsp_ascii_char),
      .rsp_last       (rsp_last)
   );

   always #2 clock = ~clock;

   // Build the expected character string for one request
   function automatic string format_number(input itoa_pkg::op_type op,
                                           input logic [31:0] value,
                                           input logic [3:0] min_w);
      logic [31:0] mag;
      logic [31:0] radix;
      logic [31:0] d;
      logic [7:0] digits[$];
      int target;
      string text;
      mag = value;
      text = "";
      radix = (op == itoa_pkg::OP_HEX || op == itoa_pkg::OP_PTR) ? 32'd16 : 32'd10;
      target = (min_w > itoa_pkg::MAX_MIN_WIDTH) ? int'(itoa_pkg::MAX_MIN_WIDTH)
                                                 : int'(min_w);
      if (op == itoa_pkg::OP_PTR) begin
         target = int'(itoa_pkg::PTR_DIGITS);
      end
      // Negate in 32 bits; the most negative value maps onto itself
      if (op == itoa_pkg::OP_SDEC && value[31]) begin
         mag = -value;
         text = "-";
      end
      do begin
         d = mag % radix;
         digits.push_front((d < 10) ? {1'b0, itoa_pkg::CHAR_ZERO} + d[7:0]
                                    : {1'b0, itoa_pkg::CHAR_A} + d[7:0] - 8'd10);
         mag = mag / radix;
      end while (mag != 0);
      if (radix == 32'd16) begin
         text = {text, "0x"};
      end
      for (int i = digits.size(); i < target; i++) begin
         text = {text, "0"};
      end
      foreach (digits[i]) begin
         text = $sformatf("%s%c", text, digits[i]);
      end
      return text;
   endfunction

   // Hold the request until accepted, then queue its characters
   task automatic offer_request(input itoa_pkg::op_type op, input logic [31:0] value,
                                input logic [3:0] min_w, input string text);
      string chars;
      expected_char_type entry;
      req_valid <= 1'b1;
      req_op <= op;
      req_value <= value;
      req_min_width <= min_w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      chars = (text.len() != 0) ? text : format_number(op, value, min_w);
      for (int i = 0; i < chars.len(); i++) begin
         entry.ch = itoa_pkg::CHAR_W'(chars[i]);
         entry.last = (i == chars.len() - 1);
         pending_chars.push_back(entry);
      end
      requests_sent++;
      op_count[op]++;
   endtask

   // Drop valid between bursts for a random gap
   task automatic pace_sender();
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 40)
                                                  : $urandom_range(1, 6);
      end
      burst_left--;
   endtask

   // Receiver: segments of full rate, random, sparse and patterned readiness, plus a long hold-off
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_asked != hold_served) begin
         rsp_ready <= 1'b0;
         hold_left <= 300;
         hold_served <= hold_served + 1;
      end else begin
         if (segment_left == 0) begin
            segment_left <= $urandom_range(5, 40);
            segment_mode <= $urandom_range(0, 3);
         end else begin
            segment_left <= segment_left - 1;
         end
         case (segment_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= (segment_left % 3 != 0);
         endcase
      end
   end

   // Compare each accepted character against the oldest expectation
   always @(posedge clock) begin : check_chars
      expected_char_type head;
      if (!reset && rsp_valid && rsp_ready) begin
         chars_seen++;
         if (pending_chars.size() == 0) begin
            mismatches++;
            if (mismatches < 30) begin
               $display("%0t: unexpected character %h (last %b)", $time,
                        rsp_ascii_char, rsp_last);
            end
         end else begin
            head = pending_chars.pop_front();
            if (rsp_ascii_char !== head.ch || rsp_last !== head.last) begin
               mismatches++;
               if (mismatches < 30) begin
                  $display("%0t: char expected %h last %b, got %h last %b", $time,
                           head.ch, head.last, rsp_ascii_char, rsp_last);
               end
            end
         end
      end
   end

   // Main sequence: directed table, then random numbers
   initial begin
      itoa_pkg::op_type op;
      logic [31:0] value;
      logic [31:0] scale;
      int drain;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_DIRECTED; i++) begin
         pace_sender();
         offer_request(directed_rows[i].op, directed_rows[i].value,
                       directed_rows[i].min_w, directed_text[i]);
      end

      for (int i = 0; i < NUM_RANDOM; i++) begin
         op = itoa_pkg::op_type'($urandom_range(0, 3));
         case ($urandom_range(0, 5))
            0: value = $urandom();
            1: value = $urandom_range(0, 999);
            2: value = $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 3)
                                            : 32'hFFFF_FFFF - $urandom_range(0, 20);
            3: begin
               scale = 32'd1;
               if (op == itoa_pkg::OP_HEX || op == itoa_pkg::OP_PTR) begin
                  scale = scale << (4 * $urandom_range(0, 7));
               end else begin
                  repeat ($urandom_range(0, 9)) scale = scale * 10;
               end
               value = scale - $urandom_range(0, 1);
            end
            4: value = 32'd1 << $urandom_range(0, 31);
            default: value = $urandom() | 32'hF000_0000;
         endcase
         // Stall the receiver for a long stretch while requests keep coming
         if (i == 150) begin
            hold_asked++;
         end
         pace_sender();
         offer_request(op, value, 4'($urandom_range(0, 15)), "");
      end
      req_valid <= 1'b0;

      // Drain, then allow the block to settle
      drain = 0;
      while (pending_chars.size() != 0 && drain < 50000) begin
         @(posedge clock);
         drain++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_chars.size() != 0) begin
         $display("%0t: %0d expected characters never arrived", $time,
                  pending_chars.size());
         mismatches++;
      end

      $display("Formatted %0d numbers (signed %0d, unsigned %0d, hex %0d, pointer %0d),",
               requests_sent, op_count[itoa_pkg::OP_SDEC], op_count[itoa_pkg::OP_UDEC],
               op_count[itoa_pkg::OP_HEX], op_count[itoa_pkg::OP_PTR]);
      $display("checked %0d characters with %0d mismatches.", chars_seen, mismatches);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #3_000_000;
      $display("Timeout after %0t", $time);
      $display("FAILED: results differ");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+sv
sv/itoa_pkg.sv
sv/itoa_radix_conv.sv
sv/integer_to_ascii_formatter.sv
dv/tb_integer_to_ascii_formatter.sv
